[src/sample_decimate_downmix_pack8_core_defines.svh]
// Assertion macros shared by the frame decimator and packer RTL.
`ifndef SAMPLE_DECIMATE_DOWNMIX_PACK8_CORE_DEFINES_SVH
`define SAMPLE_DECIMATE_DOWNMIX_PACK8_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SDMP8_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define SDMP8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/sdmp8_pkg.sv]
// Constants and types for the frame decimator, downmix and byte packer.
package sdmp8_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CLIP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START   = 3'd5;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int RATE_W   = 20;
    localparam int LEN_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;

    // Channel modes
    localparam logic [MODE_W-1:0] MODE_MONO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEREO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd2;

    // Output rate limits in hertz
    localparam logic [RATE_W-1:0] LIMIT_LOW      = 20'd28867;
    localparam logic [RATE_W-1:0] LIMIT_HIGH     = 20'd57734;
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 20'd22050;

    // One result word
    typedef struct packed {
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;
        logic              wrapped;
        logic              ended;
    } result_t;

endpackage

[src/sample_decimate_downmix_pack8_core.sv]
// A completed word is registered in the result register, or in the skid entry on a stall.
// Throughput: one input word per clock while the skid entry is empty (in_stall low).
// A two-entry output stage (result register plus skid) lets input flow while out is stalled.
// Reset: asynchronous, active low; clears state and restores register defaults.
`include "sample_decimate_downmix_pack8_core_defines.svh"

module sample_decimate_downmix_pack8_core #(
    parameter int MAX_DECIMATION = 64,
    parameter int POSITION_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [sdmp8_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdmp8_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan0_sample,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan1_sample,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan2_sample,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan3_sample,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sdmp8_pkg::WORD_W-1:0]         left_word,
    output logic [sdmp8_pkg::WORD_W-1:0]         right_word,
    output logic                                 wrapped,
    output logic                                 ended
);
    import sdmp8_pkg::*;

    localparam int PHASE_W = (MAX_DECIMATION > 1) ? $clog2(MAX_DECIMATION) : 1;
    localparam int STEP_W  = $clog2(MAX_DECIMATION + 1);
    localparam int CMP_W   = (POSITION_WIDTH > LEN_W) ? POSITION_WIDTH : LEN_W;

    // configuration registers
    logic [MODE_W-1:0]         channel_mode_reg;
    logic [RATE_W-1:0]         sample_rate_reg;
    logic                      rate_clip_reg;
    logic                      loop_enable_reg;
    logic [LEN_W-1:0]          play_length_reg;
    logic [LEN_W-1:0]          loop_start_reg;

    // playback state
    logic [PHASE_W-1:0]        phase_reg, phase_next;
    logic                      half_full_reg, half_full_next;
    logic [BYTE_W-1:0]         held_left_reg, held_left_next;
    logic [BYTE_W-1:0]         held_right_reg, held_right_next;
    logic [POSITION_WIDTH-1:0] position_reg, position_next;
    logic                      stopped_reg, stopped_next;

    // output stage
    logic                      res_valid_reg, res_valid_next;
    result_t                   res_reg, res_next;
    logic                      skid_valid_reg, skid_valid_next;
    result_t                   skid_reg, skid_next;

    // datapath
    logic                      accept;
    logic [RATE_W-1:0]         limit;
    logic [STEP_W-1:0]         step_val;
    logic                      at_end;
    logic                      do_wrap;
    logic                      do_stop;
    logic [POSITION_WIDTH-1:0] pos_base;
    logic [PHASE_W-1:0]        phase_base;
    logic [STEP_W-1:0]         phase_inc;
    logic                      kept;
    logic signed [SAMPLE_W:0]  sum_left;
    logic signed [SAMPLE_W:0]  sum_right;
    logic [BYTE_W-1:0]         left_byte;
    logic [BYTE_W-1:0]         right_byte;
    logic                      word_done;
    logic                      res_gen;
    result_t                   res_new;

    assign accept   = in_valid && !in_stall;
    assign in_stall = skid_valid_reg;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_mode_reg <= MODE_MONO;
            sample_rate_reg  <= SAMPLE_RATE_RST;
            rate_clip_reg    <= 1'b0;
            loop_enable_reg  <= 1'b0;
            play_length_reg  <= '0;
            loop_start_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CHANNEL_MODE: channel_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_SAMPLE_RATE:  sample_rate_reg  <= cfg_data[RATE_W-1:0];
                CFG_RATE_CLIP:    rate_clip_reg    <= cfg_data[0];
                CFG_LOOP_ENABLE:  loop_enable_reg  <= cfg_data[0];
                CFG_PLAY_LENGTH:  play_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_LOOP_START:   loop_start_reg   <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // derive the power-of-two decimation step from the rate
    assign limit = rate_clip_reg ? LIMIT_HIGH : LIMIT_LOW;

    always_comb
    begin
        step_val = STEP_W'(MAX_DECIMATION);
        for (int k = 8; k >= 1; k--)
        begin
            if (((1 << k) < MAX_DECIMATION) && ((sample_rate_reg >> k) <= limit))
                step_val = STEP_W'(1 << k);
        end
        if (sample_rate_reg <= limit)
            step_val = STEP_W'(1);
    end

    // check end of play before the word is used
    assign at_end     = CMP_W'(position_reg) >= CMP_W'(play_length_reg);
    assign do_wrap    = at_end && loop_enable_reg;
    assign do_stop    = at_end && !loop_enable_reg;
    assign pos_base   = do_wrap ? POSITION_WIDTH'(loop_start_reg) : position_reg;
    assign phase_base = do_wrap ? '0 : phase_reg;
    assign kept       = (phase_base == '0);
    assign phase_inc  = STEP_W'(phase_base) + STEP_W'(1);

    // pick the left and right high bytes; quad takes the floor of the average
    assign sum_left  = $signed({chan0_sample[SAMPLE_W-1], chan0_sample})
                       + $signed({chan2_sample[SAMPLE_W-1], chan2_sample});
    assign sum_right = $signed({chan1_sample[SAMPLE_W-1], chan1_sample})
                       + $signed({chan3_sample[SAMPLE_W-1], chan3_sample});

    always_comb
    begin
        if (channel_mode_reg[1])
        begin
            left_byte  = sum_left[SAMPLE_W:SAMPLE_W-BYTE_W+1];
            right_byte = sum_right[SAMPLE_W:SAMPLE_W-BYTE_W+1];
        end
        else if (channel_mode_reg == MODE_STEREO)
        begin
            left_byte  = chan0_sample[SAMPLE_W-1:SAMPLE_W-BYTE_W];
            right_byte = chan1_sample[SAMPLE_W-1:SAMPLE_W-BYTE_W];
        end
        else
        begin
            left_byte  = chan0_sample[SAMPLE_W-1:SAMPLE_W-BYTE_W];
            right_byte = chan0_sample[SAMPLE_W-1:SAMPLE_W-BYTE_W];
        end
    end

    // advance playback state and build the result
    always_comb
    begin
        phase_next      = phase_reg;
        half_full_next  = half_full_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        position_next   = position_reg;
        stopped_next    = stopped_reg;
        word_done       = 1'b0;
        res_gen         = 1'b0;
        res_new         = '0;

        if (accept && !stopped_reg)
        begin
            if (do_stop)
            begin
                // drop any held half word and stop
                stopped_next   = 1'b1;
                half_full_next = 1'b0;
                res_gen        = 1'b1;
                res_new.ended  = 1'b1;
            end
            else
            begin
                phase_next    = (phase_inc >= step_val) ? '0 : phase_inc[PHASE_W-1:0];
                position_next = pos_base + POSITION_WIDTH'(1);
                if (kept)
                begin
                    if (half_full_reg)
                    begin
                        word_done          = 1'b1;
                        half_full_next     = 1'b0;
                        res_new.left_word  = {held_left_reg, left_byte};
                        res_new.right_word = {held_right_reg, right_byte};
                    end
                    else
                    begin
                        held_left_next  = left_byte;
                        held_right_next = right_byte;
                        half_full_next  = 1'b1;
                    end
                end
                res_new.wrapped = do_wrap;
                res_gen         = word_done || do_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            half_full_reg <= 1'b0;
            position_reg  <= '0;
            stopped_reg   <= 1'b0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            half_full_reg  <= half_full_next;
            position_reg   <= position_next;
            stopped_reg    <= stopped_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

    // hold results in the output register, overflow into the skid entry
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                res_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_gen)
        begin
            if (!res_valid_reg || !out_stall)
            begin
                res_valid_next = 1'b1;
                res_next       = res_new;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = res_new;
            end
        end
        else if (!out_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = res_valid_reg;
    assign left_word  = res_reg.left_word;
    assign right_word = res_reg.right_word;
    assign wrapped    = res_reg.wrapped;
    assign ended      = res_reg.ended;

    // checks on the output stage and playback state
    `SDMP8_ASSERT_SAME(a_skid_needs_res, clk, rst_n, skid_valid_reg, res_valid_reg)
    `SDMP8_ASSERT_NEXT(a_stop_sticky, clk, rst_n, stopped_reg, stopped_reg)
    `SDMP8_ASSERT_NEXT(a_end_stops, clk, rst_n,
        accept && !stopped_reg && do_stop, stopped_reg && !half_full_reg)
    `SDMP8_ASSERT_SAME(a_flags_exclusive, clk, rst_n, res_valid_reg,
        !(res_reg.wrapped && res_reg.ended))
    `SDMP8_ASSERT_SAME(a_phase_bound, clk, rst_n, 1'b1,
        STEP_W'(phase_reg) < STEP_W'(MAX_DECIMATION))

endmodule

[verif/sdmp8_pack_checker.sv]
// Checker for the frame decimator and packer: mirrors the registers, predicts and compares words.
module sdmp8_pack_checker #(
    parameter int MAX_DECIMATION = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [sdmp8_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sdmp8_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan0_sample,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan1_sample,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan2_sample,
    input  logic signed [sdmp8_pkg::SAMPLE_W-1:0] chan3_sample,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [sdmp8_pkg::WORD_W-1:0]          left_word,
    input  logic [sdmp8_pkg::WORD_W-1:0]          right_word,
    input  logic                                  wrapped,
    input  logic                                  ended,
    output int                                    fail_count,
    output int                                    pending
);
    import sdmp8_pkg::*;

    // Register mirror
    logic [MODE_W-1:0] mode_c;
    logic [RATE_W-1:0] rate_c;
    logic              clip_c;
    logic              loop_c;
    logic [LEN_W-1:0]  len_c;
    logic [LEN_W-1:0]  start_c;

    // Playback state mirror
    int unsigned       phase_c;
    logic              half_c;
    logic [BYTE_W-1:0] held_l;
    logic [BYTE_W-1:0] held_r;
    logic [31:0]       pos_c;
    logic              stopped_c;

    result_t owed_words[$];
    int      fails = 0;

    // Power-of-two step that brings the source rate under the output limit, capped at MAX_DECIMATION
    function automatic int unsigned decim_step();
        int unsigned limit;
        int unsigned step;
        limit = clip_c ? LIMIT_HIGH : LIMIT_LOW;
        step = 1;
        if (rate_c > limit)
        begin
            step = 2;
            while (rate_c / step > limit && step < MAX_DECIMATION)
                step = step << 1;
        end
        if (step > MAX_DECIMATION)
            step = MAX_DECIMATION;
        return step;
    endfunction

    // High byte of the floored signed mean of two samples
    function automatic logic [BYTE_W-1:0] mean_hi(input logic signed [SAMPLE_W-1:0] a,
                                                  input logic signed [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0] sum;
        sum = a + b;
        return sum[SAMPLE_W:SAMPLE_W-BYTE_W+1];
    endfunction

    // Advance the playback state by one frame; return 1 when it yields a word
    function automatic bit pack_frame(input logic signed [SAMPLE_W-1:0] c0,
                                      input logic signed [SAMPLE_W-1:0] c1,
                                      input logic signed [SAMPLE_W-1:0] c2,
                                      input logic signed [SAMPLE_W-1:0] c3,
                                      output result_t word);
        bit               wrap;
        bit               done;
        bit               kept;
        int unsigned      step;
        logic [BYTE_W-1:0] lb;
        logic [BYTE_W-1:0] rb;
        word = '0;
        wrap = 1'b0;
        done = 1'b0;
        if (stopped_c)
            return 1'b0;
        // end of play: wrap to loop start, or stop and drop the held half
        if (pos_c >= len_c)
        begin
            if (loop_c)
            begin
                pos_c = start_c;
                phase_c = 0;
                wrap = 1'b1;
            end
            else
            begin
                stopped_c = 1'b1;
                half_c = 1'b0;
                word.ended = 1'b1;
                return 1'b1;
            end
        end
        step = decim_step();
        kept = (phase_c == 0);
        phase_c = (phase_c + 1 >= step) ? 0 : phase_c + 1;
        pos_c = pos_c + 1;
        if (kept)
        begin
            if ((mode_c & MODE_QUAD) != '0)
            begin
                lb = mean_hi(c0, c2);
                rb = mean_hi(c1, c3);
            end
            else if (mode_c == MODE_STEREO)
            begin
                lb = c0[SAMPLE_W-1 -: BYTE_W];
                rb = c1[SAMPLE_W-1 -: BYTE_W];
            end
            else
            begin
                lb = c0[SAMPLE_W-1 -: BYTE_W];
                rb = lb;
            end
            // pair the byte with the held one, earlier byte on top
            if (half_c)
            begin
                word.left_word = {held_l, lb};
                word.right_word = {held_r, rb};
                half_c = 1'b0;
                done = 1'b1;
            end
            else
            begin
                held_l = lb;
                held_r = rb;
                half_c = 1'b1;
            end
        end
        word.wrapped = wrap;
        return done || wrap;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        result_t seen;
        if (!rst_n)
        begin
            mode_c = MODE_MONO;
            rate_c = SAMPLE_RATE_RST;
            clip_c = 1'b0;
            loop_c = 1'b0;
            len_c = '0;
            start_c = '0;
            phase_c = 0;
            half_c = 1'b0;
            held_l = '0;
            held_r = '0;
            pos_c = '0;
            stopped_c = 1'b0;
            owed_words.delete();
            pending <= 0;
            fail_count <= fails;
        end
        else
        begin
            // compare the word the sink takes with the oldest one owed
            if (out_valid && !out_stall)
            begin
                seen.left_word = left_word;
                seen.right_word = right_word;
                seen.wrapped = wrapped;
                seen.ended = ended;
                if (owed_words.size() == 0)
                begin
                    $error("word with none owed: left_word %h right_word %h wrapped %b ended %b",
                           seen.left_word, seen.right_word, seen.wrapped, seen.ended);
                    fails++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (seen.left_word !== want.left_word)
                    begin
                        $error("left_word: expected %h, got %h", want.left_word, seen.left_word);
                        fails++;
                    end
                    if (seen.right_word !== want.right_word)
                    begin
                        $error("right_word: expected %h, got %h", want.right_word,
                               seen.right_word);
                        fails++;
                    end
                    if (seen.wrapped !== want.wrapped)
                    begin
                        $error("wrapped: expected %b, got %b", want.wrapped, seen.wrapped);
                        fails++;
                    end
                    if (seen.ended !== want.ended)
                    begin
                        $error("ended: expected %b, got %b", want.ended, seen.ended);
                        fails++;
                    end
                end
            end

            // pick up register writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_CHANNEL_MODE: mode_c = cfg_data[MODE_W-1:0];
                    CFG_SAMPLE_RATE:  rate_c = cfg_data[RATE_W-1:0];
                    CFG_RATE_CLIP:    clip_c = cfg_data[0];
                    CFG_LOOP_ENABLE:  loop_c = cfg_data[0];
                    CFG_PLAY_LENGTH:  len_c = cfg_data[LEN_W-1:0];
                    CFG_LOOP_START:   start_c = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            // predict what the accepted frame produces
            if (in_valid && !in_stall)
            begin
                if (pack_frame(chan0_sample, chan1_sample, chan2_sample, chan3_sample, want))
                    owed_words.push_back(want);
            end

            pending <= owed_words.size();
            fail_count <= fails;
        end
    end

endmodule

[verif/tb_sample_decimate_downmix_pack8_core.sv]
// Testbench top for the frame decimator and packer: clock, reset, stimulus and verdict.
module tb_sample_decimate_downmix_pack8_core;
    import sdmp8_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_FRAMES  = 1950;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SQUEEZE_CYCLES = 300;

    // Unlisted channel mode, handled as quad
    localparam logic [MODE_W-1:0] MODE_QUAD_ALT = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] chan0_sample = '0;
    logic signed [SAMPLE_W-1:0] chan1_sample = '0;
    logic signed [SAMPLE_W-1:0] chan2_sample = '0;
    logic signed [SAMPLE_W-1:0] chan3_sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [WORD_W-1:0]          left_word;
    logic [WORD_W-1:0]          right_word;
    logic                       wrapped;
    logic                       ended;
    int                         fail_count;
    int                         pending;

    bit no_gaps = 1'b0;
    bit squeeze_on = 1'b0;
    bit squeezed = 1'b0;

    sample_decimate_downmix_pack8_core DUT (
        .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .chan0_sample, .chan1_sample, .chan2_sample, .chan3_sample,
        .out_valid, .out_stall, .left_word, .right_word, .wrapped, .ended
    );

    sdmp8_pack_checker checker_i (
        .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .chan0_sample, .chan1_sample, .chan2_sample, .chan3_sample,
        .out_valid, .out_stall, .left_word, .right_word, .wrapped, .ended,
        .fail_count, .pending
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one frame after an optional gap and hold it until taken
    task automatic send_frame(input logic signed [SAMPLE_W-1:0] c0,
                              input logic signed [SAMPLE_W-1:0] c1,
                              input logic signed [SAMPLE_W-1:0] c2,
                              input logic signed [SAMPLE_W-1:0] c3);
        int unsigned gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        chan0_sample <= c0;
        chan1_sample <= c1;
        chan2_sample <= c2;
        chan3_sample <= c3;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Write all six registers back to back
    task automatic configure(input logic [MODE_W-1:0] mode, input logic [RATE_W-1:0] rate,
                             input logic clip, input logic loop,
                             input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] start);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_CHANNEL_MODE, CFG_SAMPLE_RATE, CFG_RATE_CLIP,
                CFG_LOOP_ENABLE, CFG_PLAY_LENGTH, CFG_LOOP_START};
        val = '{CFG_DATA_W'(mode), CFG_DATA_W'(rate), CFG_DATA_W'(clip),
                CFG_DATA_W'(loop), CFG_DATA_W'(len), CFG_DATA_W'(start)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid, wait until no word is owed, then let the pipe go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sink: random stalls, open stretches, and one long hold-off on request
    initial
    begin : sink
        int unsigned hold;
        int unsigned open;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze_on && !squeezed)
            begin
                hold = SQUEEZE_CYCLES;
                squeezed <= 1'b1;
            end
            else
                hold = idle_len();
            open = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(8, 1);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat (open) @(posedge clk);
        end
    end

    // Cycle limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] ext [4];
        logic [RATE_W-1:0]          rate;
        logic                       clip;
        logic                       loop;
        logic [LEN_W-1:0]           len;
        logic [LEN_W-1:0]           start;
        int unsigned                limit;
        int unsigned                pick;
        int unsigned                frames;
        int unsigned                sent;

        ext = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};
        sent = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // mono and stereo with every extreme on every channel
        for (int m = 0; m < 2; m++)
        begin
            settle();
            configure(m ? MODE_STEREO : MODE_MONO, SAMPLE_RATE_RST, 1'b0, 1'b1, '1, '0);
            for (int k = 0; k < 4; k++)
                send_frame(ext[k], ext[(k + 1) % 4], ext[(k + 2) % 4], ext[(k + 3) % 4]);
        end

        // quad downmix: same-sign extremes, odd sums that floor below zero
        settle();
        configure(MODE_QUAD, SAMPLE_RATE_RST, 1'b0, 1'b1, '1, '0);
        send_frame(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_frame(16'sh8000, 16'sh0000, 16'sh8000, 16'shFFFF);
        send_frame(16'sh0001, 16'shFFFF, 16'sh0000, 16'sh0001);
        send_frame(16'sh0080, 16'shFF7F, 16'sh0080, 16'shFF80);

        // channel mode three acts as quad; zero rate gives step one
        settle();
        configure(MODE_QUAD_ALT, '0, 1'b0, 1'b1, '1, '0);
        repeat (2) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());

        // high limit right at and just over the edge, with short loops
        settle();
        configure(MODE_STEREO, LIMIT_HIGH, 1'b1, 1'b1, 32'd3, 32'd1);
        repeat (3) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        settle();
        configure(MODE_STEREO, LIMIT_HIGH + 20'd1, 1'b1, 1'b1, 32'd3, 32'd1);
        repeat (4) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());

        // loop start past the length, then position rollover at the top of the range
        settle();
        configure(MODE_STEREO, SAMPLE_RATE_RST, 1'b0, 1'b1, '0, 32'hFFFF_FFFD);
        send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        settle();
        configure(MODE_STEREO, SAMPLE_RATE_RST, 1'b0, 1'b1, '1, '1);
        repeat (3) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());

        // largest rate: coarsest step
        settle();
        configure(MODE_MONO, '1, 1'b0, 1'b1, '1, '0);
        repeat (3) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());

        // back-to-back words while the sink holds off long enough to fill the block
        settle();
        configure(MODE_STEREO, 20'd8000, 1'b0, 1'b1, '1, '0);
        no_gaps = 1'b1;
        squeeze_on <= 1'b1;
        while (!squeezed)
        begin
            send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
            sent++;
        end
        repeat (50) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        sent += 50;
        settle();
        no_gaps = 1'b0;
        squeeze_on <= 1'b0;

        // random phases: mostly looping playback with short loops and small steps
        while (sent < RANDOM_FRAMES)
        begin
            clip = 1'($urandom_range(1));
            limit = clip ? LIMIT_HIGH : LIMIT_LOW;
            pick = $urandom_range(99);
            if (pick < 60)
                rate = RATE_W'($urandom_range(limit, 1));
            else if (pick < 85)
                rate = RATE_W'($urandom_range(4 * limit, limit + 1));
            else if (pick < 95)
                rate = RATE_W'($urandom);
            else
                rate = '0;
            loop = ($urandom_range(9) != 0);
            if (loop)
            begin
                len = $urandom_range(300, 1);
                start = $urandom_range(len + 20);
            end
            else
            begin
                // keep the end far away so playback never stops here
                len = '1;
                start = $urandom_range(32'h7FFF_FFFF);
            end
            no_gaps = ($urandom_range(4) == 0);
            frames = $urandom_range(100, 20);
            settle();
            configure(MODE_W'($urandom_range(3)), rate, clip, loop, len, start);
            repeat (frames) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
            sent += frames;
        end

        // stop with looping off: one ended word, then silence
        settle();
        no_gaps = 1'b0;
        configure(MODE_STEREO, SAMPLE_RATE_RST, 1'b0, 1'b0, '0, '0);
        repeat (8) send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        settle();

        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/sdmp8_pkg.sv
src/sample_decimate_downmix_pack8_core.sv
verif/sdmp8_pack_checker.sv
verif/tb_sample_decimate_downmix_pack8_core.sv
